// ===== rtl/multi_channel_color_fade_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the fade engine RTL
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_COLOR_FADE_ENGINE_ASSERT_SVH
`define MULTI_CHANNEL_COLOR_FADE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CFE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fade engine assertion failed");

// next-cycle implication, disabled during reset
`define CFE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fade engine assertion failed");

`endif

// ===== rtl/cfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg
// Types and constants of the color fade engine.
// ----------------------------------------------------------------------------
package cfe_pkg;

    localparam int COMP_W  = 5;
    localparam int COLOR_W = 15;
    localparam int FRAME_W = 16;
    localparam int T_W     = 17;
    localparam int CHAN_W  = 3;

    localparam logic [T_W-1:0] ONE_FIXED = 17'h10000;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [CHAN_W-1:0]  channel;
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] end_color;
        logic [FRAME_W-1:0] total_frames;
    } cfe_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic [COLOR_W-1:0] color;
        logic               fade_done;
        logic               last;
    } cfe_out_t;

    // one fade slot as stored in the slot memory
    typedef struct packed {
        logic [COLOR_W-1:0] from_color;
        logic [COLOR_W-1:0] to_color;
        logic [FRAME_W-1:0] frame_total;
        logic [FRAME_W-1:0] frame_count;
    } cfe_entry_t;

endpackage

// ===== rtl/cfe_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface cfe_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/cfe_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cfe_mem
    import cfe_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  cfe_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output cfe_entry_t    rd_data
);

    cfe_entry_t mem [DEPTH];
    cfe_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_div
// Serial restoring divider: (count << 16) / divisor, one bit per cycle.
// Expects count <= divisor, so the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module cfe_div
    import cfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FRAME_W-1:0] count,
    input  logic [FRAME_W-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [T_W-1:0]     quot
);

    localparam int STEP_W = $clog2(FRAME_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [FRAME_W-1:0] rem_reg, rem_next;
    logic [FRAME_W-1:0] dvs_reg, dvs_next;
    logic [T_W-1:0]     quot_reg, quot_next;
    logic [FRAME_W:0]   rem_sh;
    logic               bit_q;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        rem_sh    = {rem_reg, 1'b0};
        bit_q     = (rem_sh >= {1'b0, dvs_reg});
        if (start)
        begin
            // integer part is 0 or 1
            busy_next = 1'b1;
            step_next = STEP_W'(FRAME_W);
            dvs_next  = divisor;
            if (count >= divisor)
            begin
                rem_next  = count - divisor;
                quot_next = T_W'(1);
            end
            else
            begin
                rem_next  = count;
                quot_next = '0;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = bit_q ? FRAME_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[FRAME_W-1:0];
            quot_next = {quot_reg[T_W-2:0], bit_q};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/cfe_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_blend
// Linear blend of two BGR555 colors at time t (17-bit, 1.0 = 0x10000).
// ----------------------------------------------------------------------------
module cfe_blend
    import cfe_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [COLOR_W-1:0] from_color,
    input  logic [COLOR_W-1:0] to_color,
    input  logic [T_W-1:0]     t,
    output logic [COLOR_W-1:0] color
);

    localparam int PROD_W = COMP_W + T_W;

    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] mix;
    logic [T_W-1:0]     t_inv;

    always_comb
    begin
        logic [PROD_W:0] a;
        logic [PROD_W:0] b;
        logic [PROD_W:0] sum;
        t_inv = ONE_FIXED - t;
        mix   = '0;
        for (int k = 0; k < 3; k++)
        begin
            // operands widened so the products keep every bit
            a   = (PROD_W + 1)'(from_color[k*COMP_W +: COMP_W]);
            b   = (PROD_W + 1)'(to_color[k*COMP_W +: COMP_W]);
            sum = a * (PROD_W + 1)'(t_inv) + b * (PROD_W + 1)'(t);
            mix[k*COMP_W +: COMP_W] = sum[16 +: COMP_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= mix;
        end
    end

    assign color = color_reg;

endmodule

// ===== rtl/multi_channel_color_fade_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_color_fade_engine
// Per-channel linear BGR555 color fades kept in a slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)  : one item per transfer. opcode START loads the named
//                  channel (colors, frame total, count cleared, active set)
//                  and gives no result. A START on a
//                  channel at or above CHANNELS is dropped.
//   rsp  (source): one result per active channel on a TICK, in ascending
//                  channel order; last marks the final result of the tick.
//                  An idle tick gives nothing.
//   Walk: a TICK visits every slot in turn and skips the inactive ones;
//   each active one goes through memory read, serial divider for the
//   fade time, blend and output load; the divider step is skipped when
//   its frame total is 0 or 1.
//   req.ready is high only while no tick is being walked.
//   Reset clears all active flags; slot contents are left unwritten.
//   A stalled receiver holds the walk at the output register until the
//   pending result is transferred; nothing is dropped.
// ----------------------------------------------------------------------------
`include "multi_channel_color_fade_engine_assert.svh"

module multi_channel_color_fade_engine
    import cfe_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    cfe_stream_if.sink   req,
    cfe_stream_if.source rsp
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_BLEND = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CHANNELS-1:0] active_reg;
    logic [T_W-1:0]      t_reg, t_next;
    cfe_entry_t          entry_reg;
    logic                out_valid_reg;
    cfe_out_t            out_data_reg;

    // slot memory signals
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    cfe_entry_t          mem_wr_data;
    logic                mem_rd_en;
    cfe_entry_t          mem_rd_data;

    // divider signals
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [T_W-1:0]      div_quot;

    // walk controls
    logic                in_xfer;
    logic                start_wr;
    logic [IDX_W-1:0]    start_idx;
    logic                idx_last;
    logic                out_load;
    logic                entry_load;
    logic                blend_en;
    logic [FRAME_W-1:0]  new_count;
    logic                out_done;
    logic                last_cur;
    logic [CHANNELS-1:0] hi_mask;
    cfe_entry_t          start_entry;
    cfe_entry_t          wb_entry;

    assign req.ready = (state_reg == S_IDLE);
    assign in_xfer   = req.valid && req.ready;
    assign start_wr  = in_xfer && (req.payload.opcode == OP_START)
                       && (32'(req.payload.channel) < 32'(CHANNELS));
    assign start_idx = IDX_W'(req.payload.channel);
    assign idx_last  = (idx_reg == IDX_W'(CHANNELS - 1));

    // new slot from a START
    always_comb
    begin
        start_entry.from_color  = req.payload.start_color;
        start_entry.to_color    = req.payload.end_color;
        start_entry.frame_total = req.payload.total_frames;
        start_entry.frame_count = '0;
    end

    // count update, done and last flags for the slot being walked
    assign new_count = entry_reg.frame_count + FRAME_W'(1);
    assign out_done  = (new_count >= entry_reg.frame_total);

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            hi_mask[i] = (i > int'(idx_reg));
        end
    end
    assign last_cur = ~|(active_reg & hi_mask);

    always_comb
    begin
        wb_entry             = entry_reg;
        wb_entry.frame_count = new_count;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        mem_rd_en  = 1'b0;
        div_start  = 1'b0;
        entry_load = 1'b0;
        blend_en   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (req.payload.opcode == OP_TICK))
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (active_reg[idx_reg])
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_LOAD;
                end
                else if (idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_LOAD:
            begin
                entry_load = 1'b1;
                if (mem_rd_data.frame_total > FRAME_W'(1))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    // instant change: t = 1.0 gives the end color
                    t_next     = ONE_FIXED;
                    state_next = S_BLEND;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next     = (div_quot > ONE_FIXED) ? ONE_FIXED : div_quot;
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                blend_en   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load = 1'b1;
                    if (idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one write port: START load or count write-back
    assign mem_wr_en   = start_wr || out_load;
    assign mem_wr_addr = start_wr ? start_idx : idx_reg;
    assign mem_wr_data = start_wr ? start_entry : wb_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (start_wr)
            begin
                active_reg[start_idx] <= 1'b1;
            end
            else if (out_load && out_done)
            begin
                active_reg[idx_reg] <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [COLOR_W-1:0] blend_color;

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (entry_load)
        begin
            entry_reg <= mem_rd_data;
        end
        if (out_load)
        begin
            out_data_reg.out_channel <= CHAN_W'(idx_reg);
            out_data_reg.color       <= blend_color;
            out_data_reg.fade_done   <= out_done;
            out_data_reg.last        <= last_cur;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    cfe_mem #(
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    cfe_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .count   (mem_rd_data.frame_count),
        .divisor (mem_rd_data.frame_total - FRAME_W'(1)),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    cfe_blend u_blend (
        .clk        (clk),
        .en         (blend_en),
        .from_color (entry_reg.from_color),
        .to_color   (entry_reg.to_color),
        .t          (t_reg),
        .color      (blend_color)
    );

    // divider result only shows up while the walk waits for it
    `CFE_ASSERT_IMP(a_div_done_state, clk, rst_n, div_done, state_reg == S_DIV)
    // active slots keep count <= total - 1, so t never passes 1.0
    `CFE_ASSERT_IMP(a_div_range, clk, rst_n, div_done, div_quot <= ONE_FIXED)
    // divider is never left running once the walk is over
    `CFE_ASSERT_IMP(a_idle_div, clk, rst_n, state_reg == S_IDLE, !div_busy)
    // a finished fade frees its slot
    `CFE_ASSERT_NEXT(a_done_clears, clk, rst_n, out_load && out_done, !active_reg[$past(idx_reg)])

endmodule

// ===== tb/multi_channel_color_fade_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_color_fade_engine_test
// Self-checking bench for the color fade engine. A short table of directed
// fades runs first, then random start/tick traffic. Every tick is predicted
// from a behavioral copy of the slot table and the BGR555 blend, and results
// are compared in order, field by field, as they transfer out.
// ----------------------------------------------------------------------------
module multi_channel_color_fade_engine_test;
    import cfe_pkg::*;

    localparam int CHANNELS     = 8;
    localparam int RANDOM_ITEMS = 330;
    localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 200;   // > one full walk of 8 active slots
    localparam int USE_MODEL    = -1;    // row result comes from the predictor

    // one row of the directed table; typed_n is 0 or 1 where the result is
    // written in by hand, USE_MODEL otherwise
    typedef struct {
        cfe_in_t  item;
        int       typed_n;
        cfe_out_t typed;
    } fade_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cfe_stream_if #(.payload_t(cfe_in_t))  req ();
    cfe_stream_if #(.payload_t(cfe_out_t)) rsp ();

    multi_channel_color_fade_engine #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted slot table and the queue of colors still owed by the block
    // ------------------------------------------------------------------------
    logic               slot_active [CHANNELS];
    logic [COLOR_W-1:0] slot_from   [CHANNELS];
    logic [COLOR_W-1:0] slot_to     [CHANNELS];
    logic [FRAME_W-1:0] slot_total  [CHANNELS];
    logic [FRAME_W-1:0] slot_count  [CHANNELS];

    cfe_out_t  colors_due [$];
    cfe_out_t  tick_colors [$];
    fade_row_t fade_table [$];

    int fail_count  = 0;
    bit calm        = 1'b0;   // no idling on either side while set
    bit rx_hold_req = 1'b0;   // asks the receiver for one long hold-off

    // per-component linear mix, truncating; t is 16.16 fixed point, <= 1.0
    function automatic logic [COLOR_W-1:0] blend_bgr555(logic [COLOR_W-1:0] c1,
                                                        logic [COLOR_W-1:0] c2,
                                                        int unsigned t);
        logic [COLOR_W-1:0] mixed;
        int unsigned        a;
        int unsigned        b;
        int unsigned        sum;
        mixed = '0;
        for (int k = 0; k < 3; k++)
        begin
            a   = c1[k*COMP_W +: COMP_W];
            b   = c2[k*COMP_W +: COMP_W];
            sum = a * (32'h10000 - t) + b * t;
            mixed[k*COMP_W +: COMP_W] = COMP_W'(sum >> 16);
        end
        return mixed;
    endfunction

    function automatic void load_slot(cfe_in_t it);
        int ch;
        ch = it.channel;
        if (ch < CHANNELS)
        begin
            slot_from[ch]   = it.start_color;
            slot_to[ch]     = it.end_color;
            slot_total[ch]  = it.total_frames;
            slot_count[ch]  = '0;
            slot_active[ch] = 1'b1;
        end
    endfunction

    // walk the active slots in ascending order, one color each
    function automatic void predict_tick();
        int unsigned total;
        int unsigned count;
        int unsigned t;
        cfe_out_t    r;
        tick_colors.delete();
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (slot_active[ch])
            begin
                total         = slot_total[ch];
                count         = slot_count[ch];
                r.out_channel = CHAN_W'(ch);
                if (total > 1)
                begin
                    t = (count << 16) / (total - 1);
                    if (t > 32'h10000)
                        t = 32'h10000;
                    r.color = blend_bgr555(slot_from[ch], slot_to[ch], t);
                end
                else
                    r.color = slot_to[ch];   // instant change
                count          = (count + 1) & 32'hFFFF;
                slot_count[ch] = FRAME_W'(count);
                r.fade_done    = (count >= total);
                if (r.fade_done)
                    slot_active[ch] = 1'b0;
                r.last = 1'b0;
                tick_colors.push_back(r);
            end
        end
        if (tick_colors.size() > 0)
            tick_colors[$].last = 1'b1;
    endfunction

    // model update at the transfer; hand-typed rows replace the prediction
    function automatic void apply_transfer(fade_row_t row);
        if (row.item.opcode == OP_START)
            load_slot(row.item);
        else
        begin
            predict_tick();
            if (row.typed_n == USE_MODEL)
                foreach (tick_colors[i])
                    colors_due.push_back(tick_colors[i]);
            else if (row.typed_n == 1)
                colors_due.push_back(row.typed);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic cfe_in_t start_item(int ch, logic [COLOR_W-1:0] from_c,
                                           logic [COLOR_W-1:0] to_c,
                                           logic [FRAME_W-1:0] total);
        cfe_in_t it;
        it.opcode       = OP_START;
        it.channel      = CHAN_W'(ch);
        it.start_color  = from_c;
        it.end_color    = to_c;
        it.total_frames = total;
        return it;
    endfunction

    // tick: the other fields are don't-care, so they carry noise
    function automatic cfe_in_t tick_item();
        cfe_in_t it;
        it              = cfe_in_t'($bits(cfe_in_t)'({$urandom, $urandom}));
        it.opcode       = OP_TICK;
        return it;
    endfunction

    function automatic cfe_out_t color_of(int ch, logic [COLOR_W-1:0] c,
                                          logic done, logic fin);
        cfe_out_t r;
        r.out_channel = CHAN_W'(ch);
        r.color       = c;
        r.fade_done   = done;
        r.last        = fin;
        return r;
    endfunction

    function automatic void add_row(cfe_in_t it, int typed_n, cfe_out_t typed);
        fade_row_t row;
        row.item    = it;
        row.typed_n = typed_n;
        row.typed   = typed;
        fade_table.push_back(row);
    endfunction

    function automatic void build_fade_table();
        // idle tick straight after reset: nothing comes out
        add_row(tick_item(), 0, '0);
        // frame total 0 and 1 jump straight to the end color
        add_row(start_item(0, 15'h0000, 15'h7FFF, 16'd0), 0, '0);
        add_row(tick_item(), 1, color_of(0, 15'h7FFF, 1'b1, 1'b1));
        add_row(start_item(7, 15'h7FFF, 15'h0000, 16'd1), 0, '0);
        add_row(tick_item(), 1, color_of(7, 15'h0000, 1'b1, 1'b1));
        // longest fade; first frame is the start color
        add_row(start_item(3, 15'h7FFF, 15'h7FFF, 16'hFFFF), 0, '0);
        add_row(tick_item(), 1, color_of(3, 15'h7FFF, 1'b0, 1'b1));
        // two-frame fade alongside the long one
        add_row(start_item(1, 15'h001F, 15'h7C00, 16'd2), 0, '0);
        add_row(tick_item(), USE_MODEL, '0);
        add_row(tick_item(), USE_MODEL, '0);
        // restart of the long fade, plus two more short ones
        add_row(start_item(3, 15'h0000, 15'h7FFF, 16'd4), 0, '0);
        add_row(start_item(5, 15'h5555, 15'h2AAA, 16'd3), 0, '0);
        add_row(start_item(6, 15'h03E0, 15'h001F, 16'd5), 0, '0);
        repeat (5)
            add_row(tick_item(), USE_MODEL, '0);
        // all fades finished: idle again
        add_row(tick_item(), 0, '0);
    endfunction

    // mostly short fades so slots finish; now and then a long one
    function automatic cfe_in_t random_item();
        cfe_in_t it;
        int      pick;
        it       = tick_item();
        if ($urandom_range(99) < 45)
        begin
            it.opcode  = OP_START;
            it.channel = CHAN_W'($urandom_range(CHANNELS - 1));
            pick       = $urandom_range(99);
            if (pick < 70)
                it.total_frames = FRAME_W'($urandom_range(12));
            else if (pick < 92)
                it.total_frames = FRAME_W'($urandom_range(64, 13));
            else
                it.total_frames = FRAME_W'($urandom);
        end
        return it;
    endfunction

    // hold the item on req until it transfers, then update the model
    task automatic send_row(fade_row_t row);
        req.valid   <= 1'b1;
        req.payload <= row.item;
        do
            @(posedge clk);
        while (!req.ready);
        apply_transfer(row);
    endtask

    // random gap after a transfer (never while calm)
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 13)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering until every owed color has come out
    task automatic wait_colors_out();
        req.valid <= 1'b0;
        while (colors_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Sender: reset, directed table, random traffic, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        fade_row_t row;
        req.valid   <= 1'b0;
        req.payload <= '0;
        rst_n = 1'b0;
        foreach (slot_active[i])
            slot_active[i] = 1'b0;
        build_fade_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (fade_table[i])
        begin
            send_row(fade_table[i]);
            pace_sender();
        end
        wait_colors_out();

        row.typed_n = USE_MODEL;
        row.typed   = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // long receiver stall early on, while traffic keeps coming
            if (n == 60)
                rx_hold_req = 1'b1;
            calm     = (n >= 240 && n < 290);
            row.item = random_item();
            send_row(row);
            if (n == 150)
                wait_colors_out();
            else
                pace_sender();
        end
        calm = 1'b0;
        wait_colors_out();

        // a stray result would show up within one more walk
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** multi_channel_color_fade_engine: PASSED **");
        else
            $display("** multi_channel_color_fade_engine: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each rsp transfer against the oldest owed color
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cfe_out_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (colors_due.size() == 0)
            begin
                $error("unexpected result: channel %0d color %0h",
                       rsp.payload.out_channel, rsp.payload.color);
                fail_count++;
            end
            else
            begin
                want = colors_due.pop_front();
                check_field("out_channel", want.out_channel, rsp.payload.out_channel);
                check_field("color", want.color, rsp.payload.color);
                check_field("fade_done", want.fade_done, rsp.payload.fade_done);
                check_field("last", want.last, rsp.payload.last);
            end
        end
    end

    // hang guard
    initial
    begin
        #4_000_000;
        $display("** multi_channel_color_fade_engine: FAILED **");
        $finish;
    end

endmodule
